FILE: design/spq_pkg.sv
// spq_pkg: shared constants and types of the sorted priority queue
// depends on nothing; used by sorted_priority_queue_unit
package spq_pkg;

    localparam int DEPTH = 16;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    localparam logic [2:0] F_INS = 3'd0;
    localparam logic [2:0] F_POP = 3'd1;
    localparam logic [2:0] F_DEL = 3'd2;
    localparam logic [2:0] F_CLR = 3'd3;
    localparam logic [2:0] F_ALL = 3'd4;
    localparam logic [2:0] F_PRI = 3'd5;
    localparam logic [2:0] F_SRT = 3'd6;
    localparam logic [2:0] F_NOP = 3'd7;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [7:0]         prio;
        logic signed [31:0] data;
    } t_entry;

    localparam int EW = $bits(t_entry);

endpackage

FILE: design/spq_ram.sv
// spq_ram: generic single write port, single read port ram with registered read
// depends on nothing
module spq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/sorted_priority_queue_unit.sv
// sorted_priority_queue_unit: top level of the sorted priority queue
// depends on spq_pkg and spq_ram
//
// Bounded priority queue of DEPTH entries held in one ram, sorted by ascending
// priority with new entries behind equal ones. One item at a time is worked on;
// each ram step is a read, then an act, for insert, delete, pop and listings,
// and sort ties repeats bubble passes over the n entries held, up to n passes.
// Results leave through an output register, so a new item can be taken while
// the last result still waits.
module sorted_priority_queue_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [2:0]         i_func,
    input  logic signed [31:0] i_data_in,
    input  logic [7:0]         i_priority_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_status,
    output logic signed [31:0] o_data_out,
    output logic [7:0]         o_priority_out,
    output logic               o_last,
    output logic [6:0]         o_occupancy
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RD   = 2'd1;
    localparam logic [1:0] S_EV   = 2'd2;
    localparam logic [1:0] S_OUT  = 2'd3;

    logic [1:0]                  r_state, n_state;
    logic [2:0]                  r_func, n_func;
    logic signed [31:0]          r_din, n_din;
    logic [7:0]                  r_pin, n_pin;
    logic [spq_pkg::CW-1:0]      r_cnt, n_cnt;
    logic [spq_pkg::CW-1:0]      r_idx, n_idx;
    logic [spq_pkg::AW-1:0]      r_raddr, n_raddr;
    logic                        r_mode, n_mode;
    logic                        r_swap, n_swap;
    logic                        r_pend, n_pend;
    spq_pkg::t_entry             r_pent, n_pent;
    spq_pkg::t_entry             r_carry, n_carry;
    logic [1:0]                  r_res_st, n_res_st;
    spq_pkg::t_entry             r_res, n_res;
    logic                        r_ov, n_ov;
    logic [1:0]                  r_o_st, n_o_st;
    spq_pkg::t_entry             r_o_ent, n_o_ent;
    logic                        r_o_last, n_o_last;
    logic [6:0]                  r_o_occ, n_o_occ;

    logic                        we;
    logic [spq_pkg::AW-1:0]      waddr;
    spq_pkg::t_entry             wdata;
    logic [spq_pkg::EW-1:0]      rdata;
    spq_pkg::t_entry             rd;
    spq_pkg::t_entry             newent;
    logic [spq_pkg::CW-1:0]      idx_p1, idx_m1, cnt_m1;
    logic                        can_emit;

    spq_ram #(.WIDTH(spq_pkg::EW), .DEPTH(spq_pkg::DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(n_raddr),
        .o_rdata(rdata)
    );

    assign rd       = spq_pkg::t_entry'(rdata);
    assign newent   = '{prio: r_pin, data: r_din};
    assign idx_p1   = spq_pkg::CW'(r_idx + 1'b1);
    assign idx_m1   = spq_pkg::CW'(r_idx - 1'b1);
    assign cnt_m1   = spq_pkg::CW'(r_cnt - 1'b1);
    assign can_emit = !r_ov || !i_stall;

    always_comb begin
        n_state  = r_state;
        n_func   = r_func;
        n_din    = r_din;
        n_pin    = r_pin;
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        n_raddr  = r_raddr;
        n_mode   = r_mode;
        n_swap   = r_swap;
        n_pend   = r_pend;
        n_pent   = r_pent;
        n_carry  = r_carry;
        n_res_st = r_res_st;
        n_res    = r_res;
        n_ov     = r_ov && i_stall;
        n_o_st   = r_o_st;
        n_o_ent  = r_o_ent;
        n_o_last = r_o_last;
        n_o_occ  = r_o_occ;
        we       = 1'b0;
        waddr    = r_idx[spq_pkg::AW-1:0];
        wdata    = rd;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_func   = i_func;
                    n_din    = i_data_in;
                    n_pin    = i_priority_in;
                    n_idx    = '0;
                    n_mode   = 1'b0;
                    n_swap   = 1'b0;
                    n_pend   = 1'b0;
                    n_res_st = spq_pkg::ST_OK;
                    n_res    = '0;
                    if (i_func == spq_pkg::F_INS) begin
                        if (r_cnt == spq_pkg::CW'(spq_pkg::DEPTH)) begin
                            n_res_st = spq_pkg::ST_FULL;
                            n_state  = S_OUT;
                        end else begin
                            n_idx   = cnt_m1;
                            n_mode  = (r_cnt == '0);
                            n_state = S_RD;
                        end
                    end else if (i_func == spq_pkg::F_NOP) begin
                        n_state = S_OUT;
                    end else if (r_cnt == '0) begin
                        n_res_st = spq_pkg::ST_EMPTY;
                        n_state  = S_OUT;
                    end else if (i_func == spq_pkg::F_CLR) begin
                        n_cnt   = '0;
                        n_state = S_OUT;
                    end else begin
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_raddr = r_idx[spq_pkg::AW-1:0];
                n_state = S_EV;
                case (r_func)
                    spq_pkg::F_INS: begin
                        if (r_mode) begin
                            we      = 1'b1;
                            waddr   = '0;
                            wdata   = newent;
                            n_cnt   = spq_pkg::CW'(r_cnt + 1'b1);
                            n_state = S_OUT;
                        end
                    end
                    spq_pkg::F_POP, spq_pkg::F_DEL: begin
                        if (!r_mode) begin
                            if (r_idx == r_cnt) begin
                                n_res_st = spq_pkg::ST_NOTFOUND;
                                n_state  = S_OUT;
                            end
                        end else if (idx_p1 == r_cnt) begin
                            n_cnt   = cnt_m1;
                            n_state = S_OUT;
                        end else begin
                            n_raddr = idx_p1[spq_pkg::AW-1:0];
                        end
                    end
                    spq_pkg::F_PRI: begin
                        if (r_idx == r_cnt) begin
                            if (r_pend) begin
                                n_res = r_pent;
                            end else begin
                                n_res_st = spq_pkg::ST_NOTFOUND;
                            end
                            n_state = S_OUT;
                        end
                    end
                    spq_pkg::F_SRT: begin
                        if (r_idx == r_cnt) begin
                            we    = 1'b1;
                            waddr = cnt_m1[spq_pkg::AW-1:0];
                            wdata = r_carry;
                            if (r_swap) begin
                                n_idx   = '0;
                                n_swap  = 1'b0;
                                n_state = S_RD;
                            end else begin
                                n_state = S_OUT;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_EV: begin
                n_state = S_RD;
                case (r_func)
                    spq_pkg::F_INS: begin
                        waddr = idx_p1[spq_pkg::AW-1:0];
                        we    = 1'b1;
                        if (rd.prio > r_pin) begin
                            if (r_idx == '0) begin
                                n_mode = 1'b1;
                            end else begin
                                n_idx = idx_m1;
                            end
                        end else begin
                            wdata   = newent;
                            n_cnt   = spq_pkg::CW'(r_cnt + 1'b1);
                            n_state = S_OUT;
                        end
                    end
                    spq_pkg::F_POP, spq_pkg::F_DEL: begin
                        if (!r_mode) begin
                            if (r_func == spq_pkg::F_POP) begin
                                n_mode = 1'b1;
                                n_res  = rd;
                            end else if (rd.data == r_din && rd.prio == r_pin) begin
                                n_mode = 1'b1;
                            end else begin
                                n_idx = idx_p1;
                            end
                        end else begin
                            we    = 1'b1;
                            n_idx = idx_p1;
                        end
                    end
                    spq_pkg::F_ALL: begin
                        if (can_emit) begin
                            n_ov     = 1'b1;
                            n_o_st   = spq_pkg::ST_OK;
                            n_o_ent  = rd;
                            n_o_last = (idx_p1 == r_cnt);
                            n_o_occ  = 7'(r_cnt);
                            n_idx    = idx_p1;
                            n_state  = (idx_p1 == r_cnt) ? S_IDLE : S_RD;
                        end else begin
                            n_state = S_EV;
                        end
                    end
                    spq_pkg::F_PRI: begin
                        if (rd.prio == r_pin) begin
                            if (r_pend && !can_emit) begin
                                n_state = S_EV;
                            end else begin
                                if (r_pend) begin
                                    n_ov     = 1'b1;
                                    n_o_st   = spq_pkg::ST_OK;
                                    n_o_ent  = r_pent;
                                    n_o_last = 1'b0;
                                    n_o_occ  = 7'(r_cnt);
                                end
                                n_pend = 1'b1;
                                n_pent = rd;
                                n_idx  = idx_p1;
                            end
                        end else begin
                            n_idx = idx_p1;
                        end
                    end
                    spq_pkg::F_SRT: begin
                        n_idx = idx_p1;
                        if (r_idx == '0) begin
                            n_carry = rd;
                        end else begin
                            we    = 1'b1;
                            waddr = idx_m1[spq_pkg::AW-1:0];
                            if (r_carry.prio == rd.prio && r_carry.data > rd.data) begin
                                wdata  = rd;
                                n_swap = 1'b1;
                            end else begin
                                wdata   = r_carry;
                                n_carry = rd;
                            end
                        end
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_OUT: begin
                if (can_emit) begin
                    n_ov     = 1'b1;
                    n_o_st   = r_res_st;
                    n_o_ent  = r_res;
                    n_o_last = 1'b1;
                    n_o_occ  = 7'(r_cnt);
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_ov    <= n_ov;
        end
        r_func   <= n_func;
        r_din    <= n_din;
        r_pin    <= n_pin;
        r_idx    <= n_idx;
        r_raddr  <= n_raddr;
        r_mode   <= n_mode;
        r_swap   <= n_swap;
        r_pend   <= n_pend;
        r_pent   <= n_pent;
        r_carry  <= n_carry;
        r_res_st <= n_res_st;
        r_res    <= n_res;
        r_o_st   <= n_o_st;
        r_o_ent  <= n_o_ent;
        r_o_last <= n_o_last;
        r_o_occ  <= n_o_occ;
    end

    assign o_stall        = (r_state != S_IDLE);
    assign o_valid        = r_ov;
    assign o_status       = r_o_st;
    assign o_data_out     = r_o_ent.data;
    assign o_priority_out = r_o_ent.prio;
    assign o_last         = r_o_last;
    assign o_occupancy    = r_o_occ;

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= spq_pkg::CW'(spq_pkg::DEPTH))
        else $error("entry count above depth");
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_occupancy <= 7'(spq_pkg::DEPTH))
        else $error("occupancy above depth");
    a_cnt_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && $past(r_state) == S_OUT) |-> $stable(r_cnt))
        else $error("count moved while result waits");
`endif
endmodule
